// File: rtl/nms_pkg.sv
// ----------------------------------------------------------------------------
// nms_pkg
// shared types and constants for the box suppression core
// ----------------------------------------------------------------------------
package nms_pkg;

  localparam int CoordW = 14;
  localparam int SizeW  = 13;
  localparam int ScoreW = 16;
  localparam int ThrW   = 16;
  localparam logic [ThrW-1:0] ThrReset = 16'd49152;

  // stored box geometry
  typedef struct packed {
    logic [SizeW-1:0]         h;
    logic [SizeW-1:0]         w;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] x;
  } geom_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic addr_clr;
    logic addr_inc;
    logic srch_init;
    logic srch_issue;
    logic supp_issue;
    logic rd_best;
    logic capture;
    logic emit;
    logic final_flag;
    logic clear_set;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic busy;
    logic scan_last;
    logic any;
    logic out_free;
  } sts_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH,
    ST_SRCH_WAIT,
    ST_EMIT,
    ST_FETCH,
    ST_CAPT,
    ST_SUPP,
    ST_SUPP_WAIT,
    ST_CLEAR
  } state_t;

endpackage

// File: rtl/nms_if.sv
// ----------------------------------------------------------------------------
// nms channel interfaces
// box input, kept box output and threshold write channel
// ----------------------------------------------------------------------------
interface nms_box_if import nms_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] box_x;
  logic signed [CoordW-1:0] box_y;
  logic [SizeW-1:0]         box_width;
  logic [SizeW-1:0]         box_height;
  logic [ScoreW-1:0]        box_score;
  logic                     end_of_set;
  modport source (output valid, box_x, box_y, box_width, box_height, box_score,
                  end_of_set, input ready);
  modport sink (input valid, box_x, box_y, box_width, box_height, box_score,
                end_of_set, output ready);
endinterface

interface nms_kept_if import nms_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] kept_x;
  logic signed [CoordW-1:0] kept_y;
  logic [SizeW-1:0]         kept_width;
  logic [SizeW-1:0]         kept_height;
  logic [ScoreW-1:0]        kept_score;
  logic                     final_result;
  logic                     overflowed;
  modport source (output valid, kept_x, kept_y, kept_width, kept_height, kept_score,
                  final_result, overflowed, input ready);
  modport sink (input valid, kept_x, kept_y, kept_width, kept_height, kept_score,
                final_result, overflowed, output ready);
endinterface

interface nms_cfg_if import nms_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ThrW-1:0] overlap_threshold;
  modport source (output valid, overlap_threshold, input ready);
  modport sink (input valid, overlap_threshold, output ready);
endinterface

// File: rtl/nms_ctrl.sv
// ----------------------------------------------------------------------------
// nms_ctrl
// sequencer: load, max search, emit, fetch best, suppression scan
// ----------------------------------------------------------------------------
module nms_ctrl import nms_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_eos,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;
  logic   has_pend, has_pend_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      has_pend <= 1'b0;
    end else begin
      state    <= state_next;
      has_pend <= has_pend_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next    = state;
    has_pend_next = has_pend;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_eos) begin
            cmd.addr_clr  = 1'b1;
            cmd.srch_init = 1'b1;
            has_pend_next = 1'b0;
            state_next    = ST_SRCH;
          end
        end
      end
      ST_SRCH: begin
        cmd.srch_issue = 1'b1;
        cmd.addr_inc   = 1'b1;
        if (sts.scan_last) state_next = ST_SRCH_WAIT;
      end
      ST_SRCH_WAIT: begin
        if (!sts.busy) begin
          if (has_pend) state_next = ST_EMIT;
          else if (sts.any) state_next = ST_FETCH;
          else state_next = ST_CLEAR;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit       = 1'b1;
          cmd.final_flag = !sts.any;
          has_pend_next  = 1'b0;
          state_next     = sts.any ? ST_FETCH : ST_CLEAR;
        end
      end
      ST_FETCH: begin
        cmd.rd_best = 1'b1;
        state_next  = ST_CAPT;
      end
      ST_CAPT: begin
        cmd.capture   = 1'b1;
        cmd.addr_clr  = 1'b1;
        has_pend_next = 1'b1;
        state_next    = ST_SUPP;
      end
      ST_SUPP: begin
        cmd.supp_issue = 1'b1;
        cmd.addr_inc   = 1'b1;
        if (sts.scan_last) state_next = ST_SUPP_WAIT;
      end
      ST_SUPP_WAIT: begin
        if (!sts.busy) begin
          cmd.addr_clr  = 1'b1;
          cmd.srch_init = 1'b1;
          state_next    = ST_SRCH;
        end
      end
      ST_CLEAR: begin
        cmd.clear_set = 1'b1;
        state_next    = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_emit_has_pend: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> has_pend) else $error("emit without a pending box");
  a_idle_after_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_set |=> (state == ST_IDLE && in_ready)) else $error("clear not to idle");
  a_capture_after_fetch: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> $past(cmd.rd_best)) else $error("capture without fetch");

endmodule

// File: rtl/nms_dp.sv
// ----------------------------------------------------------------------------
// nms_dp
// box stores, alive mask, max search, overlap pipeline, output register
// ----------------------------------------------------------------------------
module nms_dp import nms_pkg::*; #(
  parameter int MAX_BOXES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_ready,
  nms_box_if.sink     box_in,
  nms_kept_if.source  kept_out,
  nms_cfg_if.sink     cfg,
  input  cmd_t        cmd,
  output sts_t        sts
);

  localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW = $clog2(MAX_BOXES + 1);
  localparam logic [CW-1:0] CntMax = CW'(MAX_BOXES);
  localparam logic signed [CoordW+1:0] One = 1;

  geom_t             geom_mem [MAX_BOXES];
  logic [ScoreW-1:0] score_mem [MAX_BOXES];
  geom_t             rd_geom;
  logic [ScoreW-1:0] rd_score;
  logic [AW-1:0]     rd_addr;

  logic [MAX_BOXES-1:0] alive;
  logic [CW-1:0]        count;
  logic                 overflow;
  logic [ThrW-1:0]      thr;
  logic [AW-1:0]        addr;

  logic              srch_v;
  logic [AW-1:0]     srch_idx;
  logic              any;
  logic [AW-1:0]     best_idx;
  logic [ScoreW-1:0] best_score;

  geom_t             a_geom;
  logic [ScoreW-1:0] pend_score;
  logic [2*SizeW-1:0] area_a;

  logic              v0, v1, v2;
  logic [AW-1:0]     idx0, idx1, idx2;
  logic [SizeW-1:0]  iw1, ih1, wb1, hb1;
  logic              ov1, ov2;
  logic [2*SizeW-1:0] inter2, area_b2;

  logic              kv;
  logic              kill;
  logic signed [CoordW+1:0] ax2, ay2, bx2, by2, lx, ly, rx, ry, iw, ih;
  logic [2*SizeW:0]  uni;
  logic [2*SizeW+ThrW:0] prod, lhs;

  assign cfg.ready    = 1'b1;
  assign box_in.ready = in_ready;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) thr <= ThrReset;
    else if (cfg.valid) thr <= cfg.overlap_threshold;
  end

  // box stores
  assign rd_addr = cmd.rd_best ? best_idx : addr;
  always_ff @(posedge clk) begin
    if (cmd.load && count < CntMax) begin
      geom_mem[count[AW-1:0]] <= '{h: box_in.box_height, w: box_in.box_width,
                                   y: box_in.box_y, x: box_in.box_x};
      score_mem[count[AW-1:0]] <= box_in.box_score;
    end
    rd_geom  <= geom_mem[rd_addr];
    rd_score <= score_mem[rd_addr];
  end

  // set bookkeeping and alive mask
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_set) begin
      alive    <= '0;
      count    <= '0;
      overflow <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (count < CntMax) begin
          alive[count[AW-1:0]] <= 1'b1;
          count <= count + 1'b1;
        end else begin
          overflow <= 1'b1;
        end
      end
      if (cmd.capture) alive[best_idx] <= 1'b0;
      if (v2 && kill) alive[idx2] <= 1'b0;
    end
  end

  // scan address
  always_ff @(posedge clk) begin
    if (cmd.addr_clr) addr <= '0;
    else if (cmd.addr_inc) addr <= addr + 1'b1;
  end

  // max search, ties keep the earlier entry
  always_ff @(posedge clk) begin
    if (rst) begin
      srch_v <= 1'b0;
      any    <= 1'b0;
    end else begin
      srch_v <= cmd.srch_issue;
      if (cmd.srch_init) any <= 1'b0;
      else if (srch_v && alive[srch_idx] && (!any || rd_score > best_score)) begin
        any <= 1'b1;
      end
    end
  end
  always_ff @(posedge clk) begin
    srch_idx <= addr;
    if (srch_v && alive[srch_idx] && (!any || rd_score > best_score)) begin
      best_idx   <= srch_idx;
      best_score <= rd_score;
    end
  end

  // picked box
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      a_geom     <= rd_geom;
      pend_score <= best_score;
    end
    area_a <= (2*SizeW)'(a_geom.w) * (2*SizeW)'(a_geom.h);
  end

  // overlap stage 1: intersection extents
  always_comb begin
    ax2 = (CoordW+2)'(a_geom.x) + $signed({3'b000, a_geom.w}) - One;
    ay2 = (CoordW+2)'(a_geom.y) + $signed({3'b000, a_geom.h}) - One;
    bx2 = (CoordW+2)'(rd_geom.x) + $signed({3'b000, rd_geom.w}) - One;
    by2 = (CoordW+2)'(rd_geom.y) + $signed({3'b000, rd_geom.h}) - One;
    lx  = (a_geom.x > rd_geom.x) ? (CoordW+2)'(a_geom.x) : (CoordW+2)'(rd_geom.x);
    ly  = (a_geom.y > rd_geom.y) ? (CoordW+2)'(a_geom.y) : (CoordW+2)'(rd_geom.y);
    rx  = (ax2 < bx2) ? ax2 : bx2;
    ry  = (ay2 < by2) ? ay2 : by2;
    iw  = rx - lx + One;
    ih  = ry - ly + One;
  end

  // overlap stage 3: union and threshold compare
  always_comb begin
    uni  = (2*SizeW+1)'(area_a) + (2*SizeW+1)'(area_b2) - (2*SizeW+1)'(inter2);
    prod = (2*SizeW+ThrW+1)'(thr) * (2*SizeW+ThrW+1)'(uni);
    lhs  = {1'b0, inter2, {ThrW{1'b0}}};
    kill = ov2 && (lhs > prod);
  end

  // overlap pipeline registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v0 <= cmd.supp_issue;
      v1 <= v0;
      v2 <= v1;
    end
    idx0    <= addr;
    idx1    <= idx0;
    idx2    <= idx1;
    iw1     <= iw[SizeW-1:0];
    ih1     <= ih[SizeW-1:0];
    ov1     <= (iw > 0) && (ih > 0);
    wb1     <= rd_geom.w;
    hb1     <= rd_geom.h;
    ov2     <= ov1;
    inter2  <= (2*SizeW)'(iw1) * (2*SizeW)'(ih1);
    area_b2 <= (2*SizeW)'(wb1) * (2*SizeW)'(hb1);
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) kv <= 1'b0;
    else if (cmd.emit) kv <= 1'b1;
    else if (kept_out.ready) kv <= 1'b0;
    if (cmd.emit) begin
      kept_out.kept_x       <= a_geom.x;
      kept_out.kept_y       <= a_geom.y;
      kept_out.kept_width   <= a_geom.w;
      kept_out.kept_height  <= a_geom.h;
      kept_out.kept_score   <= pend_score;
      kept_out.final_result <= cmd.final_flag;
      kept_out.overflowed   <= overflow;
    end
  end
  assign kept_out.valid = kv;

  assign sts.busy      = srch_v | v0 | v1 | v2;
  assign sts.scan_last = ((CW'(addr) + 1'b1) == count);
  assign sts.any       = any;
  assign sts.out_free  = !kv || kept_out.ready;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CntMax) else $error("count beyond capacity");
  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!kv || kept_out.ready)) else $error("result overwritten");
  a_clear_set: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_set |=> (alive == '0 && count == '0 && !overflow))
    else $error("set not cleared");

endmodule

// File: rtl/box_non_maximum_suppression_core.sv
// ----------------------------------------------------------------------------
// box_non_maximum_suppression_core
// greedy iou suppression over one set of loaded detection boxes
// ----------------------------------------------------------------------------
// channel   dir  fields
// box_in    in   box_x box_y box_width box_height box_score end_of_set
// kept_out  out  kept_x kept_y kept_width kept_height kept_score
//                final_result overflowed
// cfg       in   overlap_threshold
//
// loading takes one box per cycle while the sequencer is idle; each kept box
// costs one score scan and one overlap scan over the N loaded boxes, plus
// a fetch, a capture and an emit step; both scans step through the box
// stores one entry at a time through their single read port.
// reset is synchronous and clears the control state; no clearing pass.
// a stalled result holds the sequencer in its emit step only.
// ----------------------------------------------------------------------------
module box_non_maximum_suppression_core import nms_pkg::*; #(
  parameter int MAX_BOXES = 64
) (
  input  logic       clk,
  input  logic       rst,
  nms_box_if.sink    box_in,
  nms_kept_if.source kept_out,
  nms_cfg_if.sink    cfg
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  nms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (box_in.valid),
    .in_eos   (box_in.end_of_set),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nms_dp #(.MAX_BOXES(MAX_BOXES)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_ready (in_ready),
    .box_in   (box_in),
    .kept_out (kept_out),
    .cfg      (cfg),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

// File: dv/box_non_maximum_suppression_core_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_non_maximum_suppression_core_checker
// watches the box, kept box and threshold channels, predicts the kept boxes
// of each set by greedy iou suppression and compares them field by field
// ----------------------------------------------------------------------------
module box_non_maximum_suppression_core_checker import nms_pkg::*; #(
  parameter int MAX_BOXES = 64
) (
  input  logic       clk,
  input  logic       rst,
  nms_box_if.sink    box_mon,
  nms_kept_if.sink   kept_mon,
  nms_cfg_if.sink    cfg_mon,
  output int         fail_count,
  output int         pending_count
);

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [SizeW-1:0]         w;
    logic [SizeW-1:0]         h;
    logic [ScoreW-1:0]        score;
    logic                     last;
    logic                     ovf;
  } kept_box_t;

  kept_box_t       set_boxes[MAX_BOXES];
  int              set_count;
  bit              set_overflow;
  logic [ThrW-1:0] iou_threshold;
  kept_box_t       expected_kept[$];

  assign pending_count = expected_kept.size();

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  // true when box b overlaps box a beyond the threshold
  function automatic bit too_close(input kept_box_t a, input kept_box_t b);
    longint lx, ly, rx, ry, iw, ih, inter, uni;
    lx = (a.x > b.x) ? a.x : b.x;
    ly = (a.y > b.y) ? a.y : b.y;
    rx = (a.x + longint'(a.w) < b.x + longint'(b.w)) ?
         a.x + longint'(a.w) - 1 : b.x + longint'(b.w) - 1;
    ry = (a.y + longint'(a.h) < b.y + longint'(b.h)) ?
         a.y + longint'(a.h) - 1 : b.y + longint'(b.h) - 1;
    iw = rx - lx + 1;
    ih = ry - ly + 1;
    if (iw <= 0 || ih <= 0) return 0;
    inter = iw * ih;
    uni = longint'(a.w) * a.h + longint'(b.w) * b.h - inter;
    return inter * 65536 > longint'(iou_threshold) * uni;
  endfunction

  // greedy suppression over the loaded set
  task automatic suppress_set();
    bit alive[MAX_BOXES];
    int best, first_new;
    kept_box_t k;
    first_new = expected_kept.size();
    for (int i = 0; i < set_count; i++) alive[i] = 1;
    forever begin
      best = -1;
      for (int i = 0; i < set_count; i++)
        if (alive[i] && (best < 0 || set_boxes[i].score > set_boxes[best].score)) best = i;
      if (best < 0) break;
      alive[best] = 0;
      for (int i = 0; i < set_count; i++)
        if (alive[i] && too_close(set_boxes[best], set_boxes[i])) alive[i] = 0;
      k = set_boxes[best];
      k.last = 0;
      k.ovf = set_overflow;
      expected_kept = {expected_kept, k};
    end
    if (expected_kept.size() > first_new) expected_kept[$].last = 1;
    set_count = 0;
    set_overflow = 0;
  endtask

  always @(posedge clk) begin
    kept_box_t got, exp_box;
    if (rst) begin
      set_count = 0;
      set_overflow = 0;
      iou_threshold = ThrReset;
      fail_count = 0;
    end else begin
      // threshold write
      if (cfg_mon.valid && cfg_mon.ready) iou_threshold = cfg_mon.overlap_threshold;
      // box request
      if (box_mon.valid && box_mon.ready) begin
        if (set_count < MAX_BOXES) begin
          set_boxes[set_count] = '{box_mon.box_x, box_mon.box_y, box_mon.box_width,
                                   box_mon.box_height, box_mon.box_score, 1'b0, 1'b0};
          set_count++;
        end else begin
          set_overflow = 1;
        end
        if (box_mon.end_of_set) suppress_set();
      end
      // kept box
      if (kept_mon.valid && kept_mon.ready) begin
        got = '{kept_mon.kept_x, kept_mon.kept_y, kept_mon.kept_width,
                kept_mon.kept_height, kept_mon.kept_score, kept_mon.final_result,
                kept_mon.overflowed};
        if (expected_kept.size() == 0) begin
          report_mismatch("kept box with none expected");
        end else begin
          exp_box = expected_kept.pop_front();
          if (got.x !== exp_box.x) report_mismatch("kept_x");
          if (got.y !== exp_box.y) report_mismatch("kept_y");
          if (got.w !== exp_box.w) report_mismatch("kept_width");
          if (got.h !== exp_box.h) report_mismatch("kept_height");
          if (got.score !== exp_box.score) report_mismatch("kept_score");
          if (got.last !== exp_box.last) report_mismatch("final_result");
          if (got.ovf !== exp_box.ovf) report_mismatch("overflowed");
        end
      end
    end
  end

endmodule

// File: dv/box_non_maximum_suppression_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_non_maximum_suppression_core_tb
// directed and random box sets with random idling on both channels and
// threshold changes between sets; checking is done by the checker module
// ----------------------------------------------------------------------------
module box_non_maximum_suppression_core_tb import nms_pkg::*;;

  localparam int MaxBoxes   = 64;
  localparam int CycleLimit = 3000000;

  logic clk = 0;
  logic rst = 1;
  bit   quiet_phase = 0;
  int   fail_count, pending_count, cycle_count;

  nms_box_if  box_ch();
  nms_kept_if kept_ch();
  nms_cfg_if  cfg_ch();

  box_non_maximum_suppression_core #(.MAX_BOXES(MaxBoxes)) DUT (
    .clk(clk), .rst(rst), .box_in(box_ch.sink), .kept_out(kept_ch.source), .cfg(cfg_ch.sink)
  );

  box_non_maximum_suppression_core_checker #(.MAX_BOXES(MaxBoxes)) checker_inst (
    .clk(clk), .rst(rst), .box_mon(box_ch.sink), .kept_mon(kept_ch.sink),
    .cfg_mon(cfg_ch.sink), .fail_count(fail_count), .pending_count(pending_count)
  );

  always #5 clk = ~clk;

  initial begin
    box_ch.valid = 0; box_ch.box_x = 0; box_ch.box_y = 0; box_ch.box_width = 1;
    box_ch.box_height = 1; box_ch.box_score = 0; box_ch.end_of_set = 0;
    cfg_ch.valid = 0; cfg_ch.overlap_threshold = 0;
    kept_ch.ready = 0;
  end

  // timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side stall bursts
  initial begin
    int burst;
    cycle_count = 0;
    forever begin
      @(posedge clk);
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 12);
        kept_ch.ready <= 0;
        repeat (burst) @(posedge clk);
      end
      kept_ch.ready <= 1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // valid stays high after the request; idle gaps and drain() drop it
  task automatic send_box(input int x, input int y, input int w, input int h,
                          input int score, input bit last);
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      box_ch.valid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    box_ch.valid      <= 1;
    box_ch.box_x      <= CoordW'(x);
    box_ch.box_y      <= CoordW'(y);
    box_ch.box_width  <= SizeW'(w);
    box_ch.box_height <= SizeW'(h);
    box_ch.box_score  <= ScoreW'(score);
    box_ch.end_of_set <= last;
    do @(posedge clk); while (!box_ch.ready);
  endtask

  task automatic write_threshold(input int thr);
    cfg_ch.valid <= 1;
    cfg_ch.overlap_threshold <= ThrW'(thr);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 0;
  endtask

  // wait for all kept boxes, then a little quiet time
  task automatic drain();
    box_ch.valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // random box set; sizes mostly small and clustered so suppression happens
  task automatic random_set(input int n);
    int cx, cy;
    cx = $urandom_range(0, 16383) - 8192;
    cy = $urandom_range(0, 16383) - 8192;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_box($urandom_range(0, 16383) - 8192, $urandom_range(0, 16383) - 8192,
                 $urandom_range(1, 4096), $urandom_range(1, 4096),
                 $urandom_range(0, 65535), i == n - 1);
      else
        send_box(cx + $urandom_range(0, 40) - 20, cy + $urandom_range(0, 40) - 20,
                 $urandom_range(1, 80), $urandom_range(1, 80),
                 $urandom_range(0, 3) == 0 ? $urandom_range(0, 7) : $urandom_range(0, 65535),
                 i == n - 1);
    end
  endtask

  initial begin
    int sent;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: field extremes, equal scores, single box set
    send_box(-8192, -8192, 4096, 4096, 65535, 0);
    send_box(8191, 8191, 1, 1, 0, 0);
    send_box(-8192, -8192, 4096, 4096, 65535, 0);
    send_box(-8000, -8000, 4096, 4000, 65535, 0);
    send_box(0, 0, 1, 1, 100, 0);
    send_box(0, 0, 1, 1, 100, 1);
    drain();
    send_box(5461, -5462, 2730, 2731, 21845, 1);
    drain();
    // touching edges with no overlap, and a one-pixel corner overlap
    write_threshold(0);
    send_box(0, 0, 10, 10, 5, 0);
    send_box(10, 0, 10, 10, 6, 0);
    send_box(9, 9, 10, 10, 7, 1);
    drain();
    write_threshold(65535);
    send_box(0, 0, 10, 10, 5, 0);
    send_box(0, 0, 10, 10, 6, 1);
    drain();
    // overflow: one set beyond capacity, last two boxes dropped
    write_threshold(32768);
    for (int i = 0; i < MaxBoxes + 2; i++)
      send_box(i * 20, 0, 10, 10, $urandom_range(0, 65535), i == MaxBoxes + 1);
    drain();

    // random sets with threshold changes between them
    sent = 0;
    while (sent < 175) begin
      int n;
      if (sent > 140) quiet_phase = 1;
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 3))
          0: write_threshold(0);
          1: write_threshold(65535);
          default: write_threshold($urandom_range(0, 65535));
        endcase
      end
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 10);
      random_set(n);
      sent += n;
      drain();
    end

    drain();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
